@@ design/dbbd_pkg.sv @@
// ----------------------------------------------------------------------------
// dbbd_pkg
// Shared types and constants for the dual-camera bilinear Bayer demosaic.
// ----------------------------------------------------------------------------
package dbbd_pkg;

  localparam int SAMPLE_W = 8;
  localparam int WORD_W   = 2 * SAMPLE_W;

  typedef logic [SAMPLE_W-1:0] sample_t;

  // Bayer site class, coded as {row_odd, column_odd}.
  typedef enum logic [1:0] {
    SITE_GREEN_RED  = 2'b00,
    SITE_RED        = 2'b01,
    SITE_BLUE       = 2'b10,
    SITE_GREEN_BLUE = 2'b11
  } site_t;

  // 3x3 window of one camera's samples.
  typedef struct packed {
    sample_t c;
    sample_t n;
    sample_t s;
    sample_t w;
    sample_t e;
    sample_t nw;
    sample_t ne;
    sample_t sw;
    sample_t se;
  } win_t;

  typedef struct packed {
    sample_t red;
    sample_t green;
    sample_t blue;
  } rgb_t;

  typedef struct packed {
    rgb_t left;
    rgb_t right;
  } pix_t;

  // Output stage occupancy.
  typedef struct packed {
    logic main_valid;
    logic skid_valid;
  } ostat_t;

endpackage

@@ design/dbbd_lane.sv @@
// ----------------------------------------------------------------------------
// dbbd_lane
// Bilinear GRBG interpolation of one camera's 3x3 window.
// ----------------------------------------------------------------------------
module dbbd_lane
  import dbbd_pkg::*;
(
  input  win_t  win,
  input  site_t site,
  output rgb_t  rgb
);

  logic [SAMPLE_W:0]   vert_sum;
  logic [SAMPLE_W:0]   horiz_sum;
  logic [SAMPLE_W+1:0] cross_sum;
  logic [SAMPLE_W+1:0] diag_sum;
  sample_t vert;
  sample_t horiz;
  sample_t cross_avg;
  sample_t diag;

  assign vert_sum  = {1'b0, win.n} + {1'b0, win.s};
  assign horiz_sum = {1'b0, win.w} + {1'b0, win.e};
  assign cross_sum = {1'b0, vert_sum} + {1'b0, horiz_sum};
  assign diag_sum  = ({2'b00, win.nw} + {2'b00, win.ne})
                   + ({2'b00, win.sw} + {2'b00, win.se});

  assign vert      = vert_sum[SAMPLE_W:1];
  assign horiz     = horiz_sum[SAMPLE_W:1];
  assign cross_avg = cross_sum[SAMPLE_W+1:2];
  assign diag      = diag_sum[SAMPLE_W+1:2];

  always_comb begin
    case (site)
      SITE_GREEN_RED: begin
        rgb = '{red: horiz, green: win.c, blue: vert};
      end
      SITE_RED: begin
        rgb = '{red: win.c, green: cross_avg, blue: diag};
      end
      SITE_BLUE: begin
        rgb = '{red: diag, green: cross_avg, blue: win.c};
      end
      SITE_GREEN_BLUE: begin
        rgb = '{red: vert, green: win.c, blue: horiz};
      end
      default: begin
        rgb = '{red: vert, green: win.c, blue: horiz};
      end
    endcase
  end

endmodule

@@ design/dbbd_out_stage.sv @@
// ----------------------------------------------------------------------------
// dbbd_out_stage
// Merges both lanes into one registered item, with a skid entry for stalls.
// ----------------------------------------------------------------------------
module dbbd_out_stage
  import dbbd_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_valid,
  output logic   in_stall,
  input  rgb_t   left_rgb,
  input  rgb_t   right_rgb,
  output logic   out_valid,
  input  logic   out_stall,
  output pix_t   out_pix,
  output ostat_t stat
);

  logic main_valid_r, main_valid_nxt;
  logic skid_valid_r, skid_valid_nxt;
  pix_t main_r, main_nxt;
  pix_t skid_r, skid_nxt;
  pix_t merged;
  logic accept;

  assign merged   = '{left: left_rgb, right: right_rgb};
  assign in_stall = skid_valid_r;
  assign accept   = in_valid && !skid_valid_r;

  always_comb begin
    main_valid_nxt = main_valid_r;
    skid_valid_nxt = skid_valid_r;
    main_nxt       = main_r;
    skid_nxt       = skid_r;
    if (main_valid_r && out_stall) begin
      if (accept) begin
        skid_valid_nxt = 1'b1;
        skid_nxt       = merged;
      end
    end else if (skid_valid_r) begin
      main_valid_nxt = 1'b1;
      main_nxt       = skid_r;
      skid_valid_nxt = 1'b0;
    end else begin
      main_valid_nxt = accept;
      if (accept) begin
        main_nxt = merged;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid = main_valid_r;
  assign out_pix   = main_r;
  assign stat      = '{main_valid: main_valid_r, skid_valid: skid_valid_r};

endmodule

@@ design/dual_bayer_bilinear_demosaic_top.sv @@
// ----------------------------------------------------------------------------
// dual_bayer_bilinear_demosaic_top
// Bilinear GRBG demosaic of a 3x3 window for two cameras packed per word.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): nine 16-bit raw words of a 3x3
//   window, low byte left camera, high byte right camera, plus the centre
//   pixel's column and row parity. An item is taken when in_valid is high
//   and in_stall is low.
//   Output channel (out_valid / out_stall): RGB for the left and right
//   cameras, one result item per input item, in order.
//   Accepted items are registered in the output entry, or the skid entry
//   in a stall. Throughput is one item per cycle unless the receiver
//   stalls; both combinational lanes feed the output register directly.
//   When the receiver stalls, one more item is held in a skid entry, after
//   which in_stall rises until the receiver takes the output item; the skid
//   item then moves up and in_stall falls in the next cycle.
//   Reset (rst_n low, synchronous) empties both output entries.
// ----------------------------------------------------------------------------
module dual_bayer_bilinear_demosaic_top
  import dbbd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [WORD_W-1:0] in_centre_word,
  input  logic [WORD_W-1:0] in_north_word,
  input  logic [WORD_W-1:0] in_south_word,
  input  logic [WORD_W-1:0] in_west_word,
  input  logic [WORD_W-1:0] in_east_word,
  input  logic [WORD_W-1:0] in_northwest_word,
  input  logic [WORD_W-1:0] in_northeast_word,
  input  logic [WORD_W-1:0] in_southwest_word,
  input  logic [WORD_W-1:0] in_southeast_word,
  input  logic              in_column_odd,
  input  logic              in_row_odd,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        out_left_red,
  output logic [7:0]        out_left_green,
  output logic [7:0]        out_left_blue,
  output logic [7:0]        out_right_red,
  output logic [7:0]        out_right_green,
  output logic [7:0]        out_right_blue
);

  win_t   left_win;
  win_t   right_win;
  site_t  site;
  rgb_t   left_rgb;
  rgb_t   right_rgb;
  pix_t   out_pix;
  ostat_t stat;
  logic   in_accept;

  assign site = site_t'({in_row_odd, in_column_odd});

  assign left_win = '{
    c:  in_centre_word[SAMPLE_W-1:0],
    n:  in_north_word[SAMPLE_W-1:0],
    s:  in_south_word[SAMPLE_W-1:0],
    w:  in_west_word[SAMPLE_W-1:0],
    e:  in_east_word[SAMPLE_W-1:0],
    nw: in_northwest_word[SAMPLE_W-1:0],
    ne: in_northeast_word[SAMPLE_W-1:0],
    sw: in_southwest_word[SAMPLE_W-1:0],
    se: in_southeast_word[SAMPLE_W-1:0]
  };

  assign right_win = '{
    c:  in_centre_word[WORD_W-1:SAMPLE_W],
    n:  in_north_word[WORD_W-1:SAMPLE_W],
    s:  in_south_word[WORD_W-1:SAMPLE_W],
    w:  in_west_word[WORD_W-1:SAMPLE_W],
    e:  in_east_word[WORD_W-1:SAMPLE_W],
    nw: in_northwest_word[WORD_W-1:SAMPLE_W],
    ne: in_northeast_word[WORD_W-1:SAMPLE_W],
    sw: in_southwest_word[WORD_W-1:SAMPLE_W],
    se: in_southeast_word[WORD_W-1:SAMPLE_W]
  };

  dbbd_lane u_lane_left (
    .win  (left_win),
    .site (site),
    .rgb  (left_rgb)
  );

  dbbd_lane u_lane_right (
    .win  (right_win),
    .site (site),
    .rgb  (right_rgb)
  );

  dbbd_out_stage u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .left_rgb  (left_rgb),
    .right_rgb (right_rgb),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_pix   (out_pix),
    .stat      (stat)
  );

  assign out_left_red    = out_pix.left.red;
  assign out_left_green  = out_pix.left.green;
  assign out_left_blue   = out_pix.left.blue;
  assign out_right_red   = out_pix.right.red;
  assign out_right_green = out_pix.right.green;
  assign out_right_blue  = out_pix.right.blue;

  assign in_accept = in_valid && !in_stall;

`ifndef SYNTHESIS
  a_skid_needs_main: assert property (@(posedge clk) disable iff (!rst_n)
    stat.skid_valid |-> stat.main_valid)
    else $error("skid entry occupied while output entry empty");

  a_stalled_accept_to_skid: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && out_valid && out_stall) |=> stat.skid_valid)
    else $error("item accepted during stall was not kept in skid entry");

  a_drain_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !stat.skid_valid && !in_accept) |=> !out_valid)
    else $error("output valid without a pending item");

  a_accept_gives_valid: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> out_valid)
    else $error("accepted item did not reach the output");
`endif

endmodule
